// ----- rtl/lru_pkg.sv -----
// ----------------------------------------------------------------------------
// lru_pkg
// Shared types and constants for the LRU page replacement tracker.
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int PAGE_W = 12;
  localparam int CNT_W  = 16;
  localparam int RES_W  = 3;
  localparam int CAP_W  = 3;

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [CAP_W-1:0] CAP_RESET = 3'd4;

  typedef struct packed {
    logic              restart;
    logic [PAGE_W-1:0] page;
  } lru_in_t;

  typedef struct packed {
    logic              hit;
    logic              replaced;
    logic [PAGE_W-1:0] evicted_page;
    logic [CNT_W-1:0]  replace_count;
    logic [RES_W-1:0]  resident_count;
  } lru_out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic update;
  } lru_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } lru_sts_t;

endpackage

// ----- rtl/lru_ctrl.sv -----
// ----------------------------------------------------------------------------
// lru_ctrl
// Two-state sequencer: capture a request, then apply it to the frame table
// once the result register is free.
// ----------------------------------------------------------------------------
module lru_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lru_pkg::lru_sts_t sts,
  output lru_pkg::lru_cmd_t cmd
);
  import lru_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.update  = 1'b0;
    state_nxt   = state_r;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold the request until the previous result has been taken
        cmd.update = sts.out_free;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/lru_dp.sv -----
// ----------------------------------------------------------------------------
// lru_dp
// Frame table, recency ranks, counters, capacity register and result register.
// ----------------------------------------------------------------------------
module lru_dp #(
  parameter int FRAMES = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lru_pkg::lru_cmd_t       cmd,
  output lru_pkg::lru_sts_t       sts,
  input  lru_pkg::lru_in_t        in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output lru_pkg::lru_out_t       out_data,
  input  logic                    cfg_we,
  input  logic [lru_pkg::CAP_W-1:0] cfg_wdata
);
  import lru_pkg::*;

  localparam int OCC_W = $clog2(FRAMES + 1);
  localparam int AGE_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  lru_in_t           req_r;
  logic [CAP_W-1:0]  cap_r;
  logic [PAGE_W-1:0] frm_page_r [FRAMES];
  logic [FRAMES-1:0] frm_valid_r;
  logic [AGE_W-1:0]  frm_age_r  [FRAMES];
  logic [OCC_W-1:0]  occ_r;
  logic [CNT_W-1:0]  cnt_r;
  lru_out_t          out_r;
  logic              out_valid_r;

  logic [FRAMES-1:0] valid_eff;
  logic [OCC_W-1:0]  occ_eff;
  logic [CNT_W-1:0]  cnt_eff;
  logic [31:0]       cap_w;
  logic [31:0]       cap_sat;
  logic [OCC_W-1:0]  cap_eff;
  logic [FRAMES-1:0] hit_vec;
  logic [FRAMES-1:0] free_vec;
  logic [FRAMES-1:0] old_vec;
  logic [FRAMES-1:0] sel;
  logic              is_hit;
  logic              is_ins;
  logic              is_evict;
  logic [AGE_W-1:0]  age_sel;
  logic [PAGE_W-1:0] evicted;
  logic [AGE_W-1:0]  age_nxt [FRAMES];
  logic [OCC_W-1:0]  occ_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  lru_out_t          res;

  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    valid_eff = req_r.restart ? '0 : frm_valid_r;
    occ_eff   = req_r.restart ? '0 : occ_r;
    cnt_eff   = req_r.restart ? '0 : cnt_r;

    // capacity 0 acts as 1, anything above the frame count saturates
    cap_w = 32'(cap_r);
    if (cap_w == 32'd0) begin
      cap_sat = 32'd1;
    end else if (cap_w > 32'(FRAMES)) begin
      cap_sat = 32'(FRAMES);
    end else begin
      cap_sat = cap_w;
    end
    cap_eff = OCC_W'(cap_sat);

    for (int i = 0; i < FRAMES; i++) begin
      hit_vec[i] = valid_eff[i] && (frm_page_r[i] == req_r.page);
      // valid ranks are 0..occ-1, so the LRU frame holds rank occ-1
      old_vec[i] = valid_eff[i] && (OCC_W'(frm_age_r[i]) == occ_eff - OCC_W'(1));
    end
    free_vec = ~valid_eff & (~(~valid_eff) + FRAMES'(1));

    is_hit   = |hit_vec;
    is_ins   = !is_hit && (occ_eff < cap_eff);
    is_evict = !is_hit && !is_ins;
    sel      = is_hit ? hit_vec : (is_ins ? free_vec : old_vec);

    age_sel = '0;
    evicted = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (sel[i]) begin
        age_sel = age_sel | frm_age_r[i];
      end
      if (is_evict && old_vec[i]) begin
        evicted = evicted | frm_page_r[i];
      end
    end

    for (int i = 0; i < FRAMES; i++) begin
      if (sel[i]) begin
        age_nxt[i] = '0;
      end else if (valid_eff[i] && (!is_hit || frm_age_r[i] < age_sel)) begin
        age_nxt[i] = frm_age_r[i] + AGE_W'(1);
      end else begin
        age_nxt[i] = frm_age_r[i];
      end
    end

    occ_nxt = occ_eff + (is_ins ? OCC_W'(1) : OCC_W'(0));
    cnt_nxt = cnt_eff;
    if (is_evict && cnt_eff != CNT_MAX) begin
      cnt_nxt = cnt_eff + CNT_W'(1);
    end

    res.hit            = is_hit;
    res.replaced       = is_evict;
    res.evicted_page   = evicted;
    res.replace_count  = cnt_nxt;
    res.resident_count = RES_W'(occ_nxt);
  end

  // page tags carry no reset; they are only read behind a valid bit
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.update) begin
      out_r <= res;
      for (int i = 0; i < FRAMES; i++) begin
        if (sel[i] && !is_hit) begin
          frm_page_r[i] <= req_r.page;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      frm_valid_r <= '0;
      occ_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        frm_age_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.update) begin
        frm_valid_r <= valid_eff | sel;
        occ_r       <= occ_nxt;
        cnt_r       <= cnt_nxt;
        for (int i = 0; i < FRAMES; i++) begin
          frm_age_r[i] <= age_nxt[i];
        end
      end
      if (cmd.update) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/lru_page_replacement.sv -----
// ----------------------------------------------------------------------------
// lru_page_replacement
// Flow: an accepted request is captured into the request register, then the
// frame table and result register are updated once the result register is
// free; no new request is accepted until that update is done.
// Reset: synchronous; empties all frames, clears counters, capacity back to 4.
// No clearing pass: frame valid bits are flip-flops cleared at once.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int FRAMES = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  lru_pkg::lru_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lru_pkg::lru_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [lru_pkg::CAP_W-1:0] cfg_wdata
);
  import lru_pkg::*;

  lru_cmd_t cmd;
  lru_sts_t sts;

  lru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lru_dp #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule

// ----- rtl/lru_chk.sv -----
// ----------------------------------------------------------------------------
// lru_chk
// Port-level checks for the LRU page replacement tracker, bound to the top.
// ----------------------------------------------------------------------------
module lru_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input lru_pkg::lru_out_t         out_data
);
  import lru_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request in flight: no accept right after an accept
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted back to back");

  a_hit_repl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.hit && out_data.replaced))
    else $error("hit and replaced both set");

  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.replaced |-> out_data.evicted_page == '0)
    else $error("evicted page nonzero without replacement");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lru_page_replacement lru_chk u_chk (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for lru_page_replacement. A short table of page
// references comes first, then random references from small working sets
// under every capacity setting, then a miss stream through a single frame
// that keeps the replacement counter moving. Typed table rows are checked
// as listed, all else against an LRU predictor tracking accepted requests.
// ----------------------------------------------------------------------------
module tb_top;
  import lru_pkg::*;

  localparam int FRAMES     = 4;
  localparam int SCRIPT_LEN = 20;
  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 220;
  localparam int SAT_REQS   = 80;

  typedef struct packed {
    bit              restart;
    bit [PAGE_W-1:0] page;
    bit              typed;
    bit              hit;
    bit              repl;
    bit [PAGE_W-1:0] ev;
    bit [CNT_W-1:0]  cnt;
    bit [RES_W-1:0]  res;
  } script_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  lru_in_t           in_data;
  logic              out_valid;
  logic              out_ready = 1'b0;
  lru_out_t          out_data;
  logic              cfg_we;
  logic [CAP_W-1:0]  cfg_wdata;

  // restart, page, typed?, hit, replaced, evicted, count, resident
  script_row_t script [SCRIPT_LEN] = '{
    '{1'b0, 12'h000, 1'b1, 1'b0, 1'b0, 12'h000, 16'd0, 3'd1},
    '{1'b0, 12'hFFF, 1'b1, 1'b0, 1'b0, 12'h000, 16'd0, 3'd2},
    '{1'b0, 12'h000, 1'b1, 1'b1, 1'b0, 12'h000, 16'd0, 3'd2},
    '{1'b0, 12'h800, 1'b1, 1'b0, 1'b0, 12'h000, 16'd0, 3'd3},
    '{1'b0, 12'h001, 1'b1, 1'b0, 1'b0, 12'h000, 16'd0, 3'd4},
    '{1'b0, 12'h555, 1'b1, 1'b0, 1'b1, 12'hFFF, 16'd1, 3'd4},
    '{1'b0, 12'hAAA, 1'b1, 1'b0, 1'b1, 12'h000, 16'd2, 3'd4},
    '{1'b0, 12'h800, 1'b1, 1'b1, 1'b0, 12'h000, 16'd2, 3'd4},
    '{1'b0, 12'hFFE, 1'b0, 1'b0, 1'b0, 12'h000, 16'd0, 3'd0},
    '{1'b0, 12'h001, 1'b0, 1'b0, 1'b0, 12'h000, 16'd0, 3'd0},
    '{1'b0, 12'h7FF, 1'b0, 1'b0, 1'b0, 12'h000, 16'd0, 3'd0},
    '{1'b1, 12'h123, 1'b1, 1'b0, 1'b0, 12'h000, 16'd0, 3'd1},
    '{1'b1, 12'h123, 1'b1, 1'b0, 1'b0, 12'h000, 16'd0, 3'd1},
    '{1'b0, 12'h123, 1'b1, 1'b1, 1'b0, 12'h000, 16'd0, 3'd1},
    '{1'b0, 12'hF0F, 1'b0, 1'b0, 1'b0, 12'h000, 16'd0, 3'd0},
    '{1'b0, 12'h0F0, 1'b0, 1'b0, 1'b0, 12'h000, 16'd0, 3'd0},
    '{1'b0, 12'h123, 1'b0, 1'b0, 1'b0, 12'h000, 16'd0, 3'd0},
    '{1'b0, 12'h3C3, 1'b0, 1'b0, 1'b0, 12'h000, 16'd0, 3'd0},
    '{1'b0, 12'hC3C, 1'b0, 1'b0, 1'b0, 12'h000, 16'd0, 3'd0},
    '{1'b0, 12'h123, 1'b0, 1'b0, 1'b0, 12'h000, 16'd0, 3'd0}
  };

  // first step lowers capacity below a full table; 0, 5, 6 and 7 are out of range
  bit [CAP_W-1:0] cap_plan [PHASES] = '{3'd2, 3'd1, 3'd0, 3'd7, 3'd3, 3'd5, 3'd6, 3'd4};

  // predictor state
  bit [PAGE_W-1:0] frame_pg     [FRAMES];
  bit              frame_in_use [FRAMES];
  bit [1:0]        frame_rank   [FRAMES];
  bit [CNT_W-1:0]  evictions = '0;
  bit [RES_W-1:0]  resident  = '0;
  bit [CAP_W-1:0]  capacity  = CAP_RESET;

  lru_out_t touch_results [$];
  int       mism_count   = 0;
  int       results_seen = 0;
  int       hold_left    = 0;
  bit       hold_done    = 1'b0;
  bit       calm         = 1'b0;

  lru_page_replacement #(.FRAMES(FRAMES)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // frame f becomes most recent; valid frames younger than limit age by one
  function automatic void make_recent(int f, int limit);
    for (int i = 0; i < FRAMES; i++) begin
      if (i != f && frame_in_use[i] && frame_rank[i] < limit) frame_rank[i]++;
    end
    frame_rank[f] = '0;
  endfunction

  function automatic lru_out_t lru_touch(lru_in_t req);
    lru_out_t res;
    int       slot;
    int       cap;
    res  = '0;
    slot = -1;
    if (req.restart) begin
      frame_in_use = '{default: 1'b0};
      frame_rank   = '{default: 2'd0};
      evictions    = '0;
      resident     = '0;
    end
    cap = (capacity == 0) ? 1 : (capacity > FRAMES) ? FRAMES : int'(capacity);
    for (int i = 0; i < FRAMES; i++) begin
      if (slot < 0 && frame_in_use[i] && frame_pg[i] == req.page) slot = i;
    end
    if (slot >= 0) begin
      res.hit = 1'b1;
      make_recent(slot, frame_rank[slot]);
    end else if (resident < cap) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (slot < 0 && !frame_in_use[i]) slot = i;
      end
      if (slot >= 0) begin
        frame_in_use[slot] = 1'b1;
        frame_pg[slot]     = req.page;
        make_recent(slot, FRAMES);
        resident++;
      end
    end else begin
      // table at or above capacity: evict the oldest valid frame
      for (int i = 0; i < FRAMES; i++) begin
        if (frame_in_use[i] && (slot < 0 || frame_rank[i] > frame_rank[slot])) slot = i;
      end
      if (slot >= 0) begin
        res.replaced     = 1'b1;
        res.evicted_page = frame_pg[slot];
        if (evictions != CNT_MAX) evictions++;
        frame_pg[slot] = req.page;
        make_recent(slot, FRAMES);
      end
    end
    res.replace_count  = evictions;
    res.resident_count = resident;
    return res;
  endfunction

  task automatic flag_field(string field, longint unsigned want, longint unsigned got);
    mism_count++;
    $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
  endtask

  task automatic check_touch(lru_out_t got);
    lru_out_t want;
    if (touch_results.size() == 0) begin
      flag_field("unexpected result", 64'(0), 64'(got));
      return;
    end
    want = touch_results.pop_front();
    if (got.hit !== want.hit) flag_field("hit", 64'(want.hit), 64'(got.hit));
    if (got.replaced !== want.replaced)
      flag_field("replaced", 64'(want.replaced), 64'(got.replaced));
    if (got.evicted_page !== want.evicted_page)
      flag_field("evicted_page", 64'(want.evicted_page), 64'(got.evicted_page));
    if (got.replace_count !== want.replace_count)
      flag_field("replace_count", 64'(want.replace_count), 64'(got.replace_count));
    if (got.resident_count !== want.resident_count)
      flag_field("resident_count", 64'(want.resident_count), 64'(got.resident_count));
  endtask

  // present one request, hold it until taken, then maybe leave a gap
  task automatic offer(lru_in_t req, bit typed, lru_out_t typed_exp);
    lru_out_t predicted;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predicted = lru_touch(req);
    touch_results = {touch_results, (typed ? typed_exp : predicted)};
    if (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 17);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (touch_results.size() != 0);
  endtask

  task automatic set_capacity(bit [CAP_W-1:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    capacity  = value;
  endtask

  // result side: check, then pick next ready; one long hold-off mid-run
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_touch(out_data);
      results_seen++;
    end
    if (results_seen == 600 && !hold_done) begin
      hold_left = 60;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 17);
    end
  end

  initial begin : stimulus
    script_row_t     row;
    lru_in_t         req;
    lru_out_t        typed_exp;
    bit [PAGE_W-1:0] working [6];
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[k]) begin
      row         = script[k];
      req.restart = row.restart;
      req.page    = row.page;
      typed_exp   = {row.hit, row.repl, row.ev, row.cnt, row.res};
      offer(req, row.typed, typed_exp);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph == 4);
      set_capacity(cap_plan[ph]);
      foreach (working[w]) working[w] = PAGE_W'($urandom_range(4095));
      repeat (PHASE_REQS) begin
        req.restart = ($urandom_range(99) < 3);
        req.page    = ($urandom_range(99) < 80) ? working[$urandom_range(5)]
                                                : PAGE_W'($urandom_range(4095));
        offer(req, 1'b0, '0);
      end
    end
    calm = 1'b0;

    // one frame, every request a miss: each one after the first replaces
    set_capacity(3'd1);
    for (int n = 0; n < SAT_REQS; n++) begin
      req.restart = (n == 0);
      req.page    = n[PAGE_W-1:0];
      offer(req, 1'b0, '0);
    end
    foreach (working[w]) working[w] = PAGE_W'($urandom_range(4095));
    repeat (40) begin
      req.restart = 1'b0;
      req.page    = working[$urandom_range(1)];
      offer(req, 1'b0, '0);
    end

    drain();
    repeat (8) @(posedge clk);
    if (mism_count == 0 && touch_results.size() == 0) begin
      $display("lru_page_replacement: match");
    end else begin
      $display("lru_page_replacement: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("lru_page_replacement: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lru_pkg.sv
rtl/lru_ctrl.sv
rtl/lru_dp.sv
rtl/lru_page_replacement.sv
rtl/lru_chk.sv
dv/tb_top.sv
